// ===== hw/rtl/versatile_interface_adapter_timers_unit_macros.svh =====
// Assertion macros shared by the checker module of the timer and port adapter.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef VERSATILE_INTERFACE_ADAPTER_TIMERS_UNIT_MACROS_SVH
`define VERSATILE_INTERFACE_ADAPTER_TIMERS_UNIT_MACROS_SVH

// Consequent checked at the same edge as the antecedent, disabled in reset.
`define VIAT_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adapter check failed");

// Consequent checked at the edge after the antecedent, disabled in reset.
`define VIAT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adapter check failed");

// Consequent checked at the following edge, active through reset as well.
`define VIAT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("adapter check failed");

`endif

// ===== hw/rtl/viat_pkg.sv =====
// Shared types and constants of the timer and port adapter.
// Used by the controller, the datapath, the top level and the checker.
package viat_pkg;

  // Request kinds carried in req_type.
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Standard register map.
  localparam logic [3:0] REG_ORB    = 4'd0;
  localparam logic [3:0] REG_ORA    = 4'd1;
  localparam logic [3:0] REG_DDRB   = 4'd2;
  localparam logic [3:0] REG_DDRA   = 4'd3;
  localparam logic [3:0] REG_T1CL   = 4'd4;
  localparam logic [3:0] REG_T1CH   = 4'd5;
  localparam logic [3:0] REG_T1LL   = 4'd6;
  localparam logic [3:0] REG_T1LH   = 4'd7;
  localparam logic [3:0] REG_T2CL   = 4'd8;
  localparam logic [3:0] REG_T2CH   = 4'd9;
  localparam logic [3:0] REG_SR     = 4'd10;
  localparam logic [3:0] REG_ACR    = 4'd11;
  localparam logic [3:0] REG_PCR    = 4'd12;
  localparam logic [3:0] REG_IFR    = 4'd13;
  localparam logic [3:0] REG_IER    = 4'd14;
  localparam logic [3:0] REG_ORA_NH = 4'd15;

  // Bit positions in the flag, enable and auxiliary control registers.
  localparam int FLAG_T1_BIT     = 6;
  localparam int FLAG_T2_BIT     = 5;
  localparam int ACR_T1_FREE_BIT = 6;
  localparam int ACR_T2_PULSE_BIT = 5;

  // Counter constants.
  localparam int CNT_W = 18;
  localparam logic [CNT_W-1:0] CNT_RESET = 18'h0FFFF;
  localparam logic [CNT_W-1:0] CNT_WRAP  = 18'h10000;
  localparam logic [CNT_W-1:0] CNT_RELOAD_EXTRA = 18'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
    logic [7:0] pins_a;
    logic [7:0] pins_b;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_T1_LOOP,
    ST_T2,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic exec;
    logic t1_step;
    logic t2_step;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic t1_negative;
  } dp_status_t;

endpackage

// ===== hw/rtl/versatile_interface_adapter_timers_unit.sv =====
// Timer and port core of a 6522-style interface adapter, one result item per request.
// A read or write is accepted, executed, then loaded into the result register; a tick also
// runs the T1 loop, N T1 underflows at one reload add per cycle (N <= 128), then a T2 step.
// The next item is taken only after the result is loaded, which stalls while the result
// register is full and not drained; the result waits there while the next item is taken.
// Reset (rst, synchronous): registers but item and result data reset, no result pending.
module versatile_interface_adapter_timers_unit
  import viat_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_item
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer.
  viat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Registers, timers and result register.
  viat_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req_item (req_item),
    .status   (status),
    .rsp_item (rsp_item)
  );

endmodule

// ===== hw/rtl/viat_dp.sv =====
// Datapath of the timer and port adapter: register file, timers and result register.
// Depends on viat_pkg; driven by commands from viat_ctrl.
module viat_dp
  import viat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  ctrl_cmd_t  cmd,
  input  req_item_t  req_item,
  output dp_status_t status,
  output rsp_item_t  rsp_item
);

  req_item_t        item;
  logic [7:0]       read_byte;
  logic [7:0]       port_b_out;
  logic [7:0]       port_a_out;
  logic [7:0]       dir_b;
  logic [7:0]       dir_a;
  logic [CNT_W-1:0] timer1_count;
  logic [15:0]      timer1_reload;
  logic             timer1_live;
  logic [CNT_W-1:0] timer2_count;
  logic [7:0]       timer2_low_hold;
  logic             timer2_live;
  logic [7:0]       shift_byte;
  logic [7:0]       aux_control;
  logic [7:0]       periph_control;
  logic [6:0]       flag_bits;
  logic [6:0]       enable_bits;

  logic             irq_now;
  logic [7:0]       read_mux;
  logic [CNT_W-1:0] cycles_ext;
  logic [CNT_W-1:0] t1_addend;
  logic [CNT_W-1:0] t2_diff;

  assign irq_now    = |(flag_bits & enable_bits);
  assign cycles_ext = {{(CNT_W-8){1'b0}}, item.tick_cycles};
  assign t2_diff    = timer2_count - cycles_ext;

  // Free-run reloads from the latch plus two; one-shot wraps by a full period.
  assign t1_addend = aux_control[ACR_T1_FREE_BIT]
                   ? ({2'b00, timer1_reload} + CNT_RELOAD_EXTRA) : CNT_WRAP;

  assign status.is_tick     = (item.req_type == REQ_TICK);
  assign status.t1_negative = timer1_count[CNT_W-1];

  // Read multiplexer over the register map.
  always_comb begin
    case (item.reg_index)
      REG_ORB:            read_mux = (port_b_out & dir_b) | (item.pins_b & ~dir_b);
      REG_ORA, REG_ORA_NH: read_mux = (port_a_out & dir_a) | (item.pins_a & ~dir_a);
      REG_DDRB:           read_mux = dir_b;
      REG_DDRA:           read_mux = dir_a;
      REG_T1CL:           read_mux = timer1_count[7:0];
      REG_T1CH:           read_mux = timer1_count[15:8];
      REG_T1LL:           read_mux = timer1_reload[7:0];
      REG_T1LH:           read_mux = timer1_reload[15:8];
      REG_T2CL:           read_mux = timer2_count[7:0];
      REG_T2CH:           read_mux = timer2_count[15:8];
      REG_SR:             read_mux = shift_byte;
      REG_ACR:            read_mux = aux_control;
      REG_PCR:            read_mux = periph_control;
      REG_IFR:            read_mux = {irq_now, flag_bits};
      default:            read_mux = {1'b1, enable_bits};
    endcase
  end

  // Captured request; it stays put until the next accepted item.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= req_item;
    end
  end

  // Result register, loaded once the item has fully executed.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_item.read_data <= read_byte;
      rsp_item.irq       <= irq_now;
    end
  end

  // Architectural state: bus accesses, tick subtraction, T1 reload steps, T2 step.
  always_ff @(posedge clk) begin
    if (rst) begin
      read_byte       <= '0;
      port_b_out      <= '0;
      port_a_out      <= '0;
      dir_b           <= '0;
      dir_a           <= '0;
      timer1_count    <= CNT_RESET;
      timer1_reload   <= '0;
      timer1_live     <= 1'b0;
      timer2_count    <= CNT_RESET;
      timer2_low_hold <= '0;
      timer2_live     <= 1'b0;
      shift_byte      <= '0;
      aux_control     <= '0;
      periph_control  <= '0;
      flag_bits       <= '0;
      enable_bits     <= '0;
    end else begin
      if (cmd.exec) begin
        read_byte <= '0;
        case (item.req_type)
          REQ_READ: begin
            read_byte <= read_mux;
            if (item.reg_index == REG_T1CL) begin
              flag_bits[FLAG_T1_BIT] <= 1'b0;
            end
            if (item.reg_index == REG_T2CL) begin
              flag_bits[FLAG_T2_BIT] <= 1'b0;
            end
          end
          REQ_WRITE: begin
            case (item.reg_index)
              REG_ORB:             port_b_out <= item.write_data;
              REG_ORA, REG_ORA_NH: port_a_out <= item.write_data;
              REG_DDRB:            dir_b <= item.write_data;
              REG_DDRA:            dir_a <= item.write_data;
              REG_T1CL, REG_T1LL:  timer1_reload[7:0] <= item.write_data;
              REG_T1CH: begin
                timer1_reload[15:8]    <= item.write_data;
                timer1_count           <= {2'b00, item.write_data, timer1_reload[7:0]};
                timer1_live            <= 1'b1;
                flag_bits[FLAG_T1_BIT] <= 1'b0;
              end
              REG_T1LH: begin
                timer1_reload[15:8]    <= item.write_data;
                flag_bits[FLAG_T1_BIT] <= 1'b0;
              end
              REG_T2CL:            timer2_low_hold <= item.write_data;
              REG_T2CH: begin
                timer2_count           <= {2'b00, item.write_data, timer2_low_hold};
                timer2_live            <= 1'b1;
                flag_bits[FLAG_T2_BIT] <= 1'b0;
              end
              REG_SR:              shift_byte <= item.write_data;
              REG_ACR:             aux_control <= item.write_data;
              REG_PCR:             periph_control <= item.write_data;
              REG_IFR:             flag_bits <= flag_bits & ~item.write_data[6:0];
              default: begin
                if (item.write_data[7]) begin
                  enable_bits <= enable_bits | item.write_data[6:0];
                end else begin
                  enable_bits <= enable_bits & ~item.write_data[6:0];
                end
              end
            endcase
          end
          REQ_TICK: begin
            timer1_count <= timer1_count - cycles_ext;
          end
          default: begin
          end
        endcase
      end

      // One underflow of T1 per cycle.
      if (cmd.t1_step) begin
        if (timer1_live) begin
          flag_bits[FLAG_T1_BIT] <= 1'b1;
        end
        if (!aux_control[ACR_T1_FREE_BIT]) begin
          timer1_live <= 1'b0;
        end
        timer1_count <= timer1_count + t1_addend;
      end

      // T2 counts down unless in pulse mode; an underflow wraps to the low 16 bits.
      if (cmd.t2_step && !aux_control[ACR_T2_PULSE_BIT]) begin
        if (t2_diff[CNT_W-1]) begin
          if (timer2_live) begin
            flag_bits[FLAG_T2_BIT] <= 1'b1;
          end
          timer2_live  <= 1'b0;
          timer2_count <= {2'b00, t2_diff[15:0]};
        end else begin
          timer2_count <= t2_diff;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/viat_ctrl.sv =====
// Controller of the timer and port adapter: sequences one item through the datapath.
// Depends on viat_pkg; issues commands to viat_dp and owns the result valid flag.
module viat_ctrl
  import viat_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   out_full;
  logic   can_load;

  assign can_load  = !out_full || rsp_ready;
  assign rsp_valid = out_full;

  // State register and result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_full <= 1'b1;
      end else if (rsp_ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = status.is_tick ? ST_T1_LOOP : ST_FINISH;
      end
      ST_T1_LOOP: begin
        if (!status.t1_negative) begin
          state_next = ST_T2;
        end
      end
      ST_T2: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_T1_LOOP: begin
        cmd.t1_step = status.t1_negative;
      end
      ST_T2: begin
        cmd.t2_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.out_load = can_load;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/viat_sva.sv =====
// Port-level checker for the timer and port adapter, bound to the top level.
// Depends on viat_pkg and the assertion macros header.
`include "versatile_interface_adapter_timers_unit_macros.svh"

module viat_sva
  import viat_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_item_t rsp_item
);

  // An accepted item occupies the block for at least the following cycle.
  `VIAT_ASSERT_NEXT(busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // A new result only appears when the block has just been busy.
  `VIAT_ASSERT_SAME(result_after_work, clk, rst, $rose(rsp_valid), !$past(req_ready))

  // A stalled result holds its value.
  `VIAT_ASSERT_NEXT(result_holds, clk, rst, rsp_valid && !rsp_ready,
                    rsp_valid && $stable(rsp_item))

  // Reset leaves the block idle with nothing to deliver.
  `VIAT_ASSERT_NEXT_ALWAYS(idle_after_reset, clk, rst, !rsp_valid && req_ready)

endmodule

bind versatile_interface_adapter_timers_unit viat_sva u_sva (.*);
